[hdl/ale_pkg.sv]
// Shared types and constants for the AT line extractor.
// No dependencies; imported by ale_match, ale_seq and at_line_extractor.
`timescale 1ns / 1ps

package ale_pkg;

    localparam int SEQ_SLOTS          = 4;
    localparam int PATTERN_BYTES      = 4;
    localparam int CTRL_W             = 5;
    localparam int CTRL_VALUE_PASS    = 3;
    localparam int CTRL_EXPLICIT_PASS = 4;

    localparam logic [7:0] CHAR_LT = 8'h3C;
    localparam logic [7:0] CHAR_GT = 8'h3E;

    typedef enum logic [1:0] {
        KIND_RESPONSE = 2'd0,
        KIND_PROMPT   = 2'd1,
        KIND_OVERFLOW = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REG_SEQ0_PATTERN = 3'd0,
        REG_SEQ1_PATTERN = 3'd1,
        REG_SEQ2_PATTERN = 3'd2,
        REG_SEQ3_PATTERN = 3'd3,
        REG_SEQ0_CONTROL = 3'd4,
        REG_SEQ1_CONTROL = 3'd5,
        REG_SEQ2_CONTROL = 3'd6,
        REG_SEQ3_CONTROL = 3'd7
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_LINE,
        ST_TERM,
        ST_OVF
    } state_t;

    typedef struct packed {
        logic        hit;
        logic [2:0]  len;
        logic        first_lt;
        logic        last_gt;
        logic        value_pass;
        logic        explicit_pass;
        logic [31:0] pattern;
    } match_t;

endpackage

[hdl/ale_ring.sv]
// Byte ring storage: one write port, one registered read port.
// Depends on nothing; instantiated by at_line_extractor.
`timescale 1ns / 1ps

module ale_ring #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/ale_match.sv]
// Terminator matcher: keeps the newest stored bytes and picks the winning sequence.
// Depends on ale_pkg; instantiated by at_line_extractor.
`timescale 1ns / 1ps

module ale_match #(
    parameter int MAX_SEQ_LEN = 4,
    parameter int NUM_SEQ     = 4,
    parameter int CW          = 6
) (
    input  logic                                        clk,
    input  logic                                        store,
    input  logic [7:0]                                  store_byte,
    input  logic [CW-1:0]                               fill,
    input  logic [ale_pkg::SEQ_SLOTS-1:0][31:0]         seq_pattern,
    input  logic [ale_pkg::SEQ_SLOTS-1:0][ale_pkg::CTRL_W-1:0] seq_control,
    output ale_pkg::match_t                             result
);
    import ale_pkg::*;

    localparam int EFF  = (MAX_SEQ_LEN < PATTERN_BYTES) ? MAX_SEQ_LEN : PATTERN_BYTES;
    localparam int HIST = EFF + 1;

    logic [7:0] hist_reg [HIST];
    logic       first_lt_reg;

    // hist_reg[0] is the newest byte
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            hist_reg[0] <= store_byte;
            for (int i = 1; i < HIST; i++)
            begin
                hist_reg[i] <= hist_reg[i-1];
            end
            if (fill == '0)
            begin
                first_lt_reg <= (store_byte == CHAR_LT);
            end
        end
    end

    always_comb
    begin
        logic [2:0] len;
        logic [2:0] best_len;
        logic [1:0] best_k;
        logic       hit;
        logic       m;
        logic       ok;
        logic       gt;
        best_len = '0;
        best_k   = '0;
        hit      = 1'b0;
        for (int k = 0; k < NUM_SEQ; k++)
        begin
            len = seq_control[k][2:0];
            m   = 1'b0;
            for (int l = 1; l <= EFF; l++)
            begin
                ok = 1'b1;
                for (int j = 0; j < l; j++)
                begin
                    if (seq_pattern[k][8*j +: 8] != hist_reg[l-1-j])
                    begin
                        ok = 1'b0;
                    end
                end
                if (len == 3'(l))
                begin
                    m = ok;
                end
            end
            if (m && (CW'(len) <= fill) && (len > best_len))
            begin
                hit      = 1'b1;
                best_len = len;
                best_k   = 2'(k);
            end
        end
        gt = 1'b0;
        for (int i = 0; i < HIST; i++)
        begin
            if (best_len == 3'(i))
            begin
                gt = (hist_reg[i] == CHAR_GT);
            end
        end
        result.hit           = hit;
        result.len           = best_len;
        result.first_lt      = first_lt_reg;
        result.last_gt       = gt;
        result.value_pass    = seq_control[best_k][CTRL_VALUE_PASS];
        result.explicit_pass = seq_control[best_k][CTRL_EXPLICIT_PASS];
        result.pattern       = seq_pattern[best_k];
    end

endmodule

[hdl/ale_seq.sv]
// Sequencer: ring pointers, byte intake, line and terminator emission, output register.
// Depends on ale_pkg; drives ale_ring and reads ale_match results.
`timescale 1ns / 1ps

module ale_seq #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,
    output logic [1:0]      m_tuser,
    output logic            m_tlast,
    output logic            wr_en,
    output logic [AW-1:0]   wr_addr,
    output logic [7:0]      wr_data,
    output logic            rd_en,
    output logic [AW-1:0]   rd_addr,
    input  logic [7:0]      rd_data,
    input  ale_pkg::match_t match,
    output logic [CW-1:0]   fill
);
    import ale_pkg::*;

    localparam int SW = AW + 2;

    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] rem_reg;
    logic          rd_pend_reg;
    logic          out_valid_reg;
    logic [AW-1:0] addr_reg;
    logic          pend_last_reg;
    kind_t         line_kind_reg;
    logic [31:0]   term_pat_reg;
    logic [2:0]    term_len_reg;
    logic [1:0]    term_i_reg;
    logic          explicit_reg;
    logic [7:0]    out_byte_reg;
    kind_t         out_kind_reg;
    logic          out_last_reg;

    logic          accept, full, out_free, land, issue, line_done;
    logic          term_load, term_end, ovf_load;
    logic [CW-1:0] n, cnt;
    logic          wrapped;
    logic [SW-1:0] start_sum;
    logic [AW-1:0] line_start;

    assign accept    = s_tvalid && (state_reg == ST_IDLE);
    assign full      = (fill_reg == CW'(DEPTH));
    assign out_free  = !out_valid_reg || m_tready;
    assign land      = rd_pend_reg && out_free;
    assign issue     = (state_reg == ST_LINE) && (rem_reg != '0) && (!rd_pend_reg || land);
    assign line_done = (state_reg == ST_LINE) && (rem_reg == '0) && (!rd_pend_reg || land);
    assign term_load = (state_reg == ST_TERM) && out_free;
    assign term_end  = term_load && ((3'(term_i_reg) + 3'd1) == term_len_reg);
    assign ovf_load  = (state_reg == ST_OVF) && out_free;

    assign n       = fill_reg - CW'(match.len);
    assign wrapped = (n >= CW'(3)) && match.first_lt && match.last_gt;
    assign cnt     = wrapped ? (n - CW'(2)) : n;

    // oldest stored byte, plus one when the opening bracket is stripped
    always_comb
    begin
        start_sum = SW'(head_reg) + SW'(DEPTH) - SW'(fill_reg) + SW'(wrapped);
        if (start_sum >= SW'(DEPTH))
        begin
            start_sum = start_sum - SW'(DEPTH);
        end
        line_start = start_sum[AW-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = full ? ST_OVF : ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (!match.hit || (n == '0))
                begin
                    state_next = ST_IDLE;
                end
                else if (match.value_pass)
                begin
                    state_next = ST_LINE;
                end
                else if (match.explicit_pass)
                begin
                    state_next = ST_TERM;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LINE:
            begin
                if (line_done)
                begin
                    state_next = explicit_reg ? ST_TERM : ST_IDLE;
                end
            end
            ST_TERM:
            begin
                if (term_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OVF:
            begin
                if (ovf_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        wr_en    = accept && !full;
        wr_addr  = head_reg;
        wr_data  = s_tdata;
        rd_en    = issue;
        rd_addr  = addr_reg;
        m_tvalid = out_valid_reg;
        m_tdata  = out_byte_reg;
        m_tuser  = out_kind_reg;
        m_tlast  = out_last_reg;
        fill     = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            rem_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && !full)
            begin
                head_reg <= (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg + 1'b1;
            end
            else if ((state_reg == ST_MATCH) && match.hit)
            begin
                fill_reg <= '0;
            end
            if (state_reg == ST_MATCH)
            begin
                rem_reg <= cnt;
            end
            else if (issue)
            begin
                rem_reg <= rem_reg - 1'b1;
            end
            if (issue)
            begin
                rd_pend_reg <= 1'b1;
            end
            else if (land)
            begin
                rd_pend_reg <= 1'b0;
            end
            if (land || term_load || ovf_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MATCH)
        begin
            addr_reg      <= line_start;
            line_kind_reg <= wrapped ? KIND_PROMPT : KIND_RESPONSE;
            term_pat_reg  <= match.pattern;
            term_len_reg  <= match.len;
            explicit_reg  <= match.explicit_pass;
            term_i_reg    <= '0;
        end
        if (issue)
        begin
            addr_reg      <= (addr_reg == AW'(DEPTH - 1)) ? '0 : addr_reg + 1'b1;
            pend_last_reg <= (rem_reg == CW'(1));
        end
        if (land)
        begin
            out_byte_reg <= rd_data;
            out_kind_reg <= line_kind_reg;
            out_last_reg <= pend_last_reg;
        end
        else if (term_load)
        begin
            out_byte_reg <= term_pat_reg[8*term_i_reg +: 8];
            out_kind_reg <= KIND_PROMPT;
            out_last_reg <= term_end;
            term_i_reg   <= term_i_reg + 1'b1;
        end
        else if (ovf_load)
        begin
            out_byte_reg <= '0;
            out_kind_reg <= KIND_OVERFLOW;
            out_last_reg <= 1'b1;
        end
    end

endmodule

[hdl/at_line_extractor.sv]
// Top level of the AT line extractor: configuration registers and block wiring.
// Depends on ale_pkg, ale_ring, ale_match and ale_seq.
// Usage:
//   s_axis carries one received modem byte per transfer in tdata.
//   m_axis carries the result stream: tdata the message byte, tuser the kind
//   (response byte, prompt byte, overflow) and tlast the final byte of a message.
//   cfg_wen/cfg_index/cfg_data write the four terminator patterns and the four
//   control words; write them only while the block is idle.
// Operation:
//   A byte that emits nothing is stored in the ring in ST_IDLE, then the newest
//   bytes are compared against the terminators in ST_MATCH.
//   On a match with value pass set, the line is read back from the ring memory
//   through its registered read port at one byte per cycle while the receiver
//   accepts; with explicit pass set, the terminator bytes follow, after any line,
//   at one per cycle while the receiver accepts.
//   A byte that arrives with the ring full yields one overflow transfer.
// Reset empties the ring and clears all configuration to zero; the ring
// memory itself is not cleared. When the receiver stalls, the output register
// holds its transfer and emission pauses; no input is taken until the current
// byte's last result has been loaded into the output register.
`timescale 1ns / 1ps

module at_line_extractor #(
    parameter int DEPTH       = 32,
    parameter int MAX_SEQ_LEN = 4,
    parameter int NUM_SEQ     = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,   // [1:0] out_kind
    output logic        m_axis_tlast,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ale_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [SEQ_SLOTS-1:0][31:0]       pattern_reg;
    logic [SEQ_SLOTS-1:0][CTRL_W-1:0] control_reg;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    logic [CW-1:0] fill;
    match_t        match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            control_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SEQ0_PATTERN: pattern_reg[0] <= cfg_data;
                REG_SEQ1_PATTERN: pattern_reg[1] <= cfg_data;
                REG_SEQ2_PATTERN: pattern_reg[2] <= cfg_data;
                REG_SEQ3_PATTERN: pattern_reg[3] <= cfg_data;
                REG_SEQ0_CONTROL: control_reg[0] <= cfg_data[CTRL_W-1:0];
                REG_SEQ1_CONTROL: control_reg[1] <= cfg_data[CTRL_W-1:0];
                REG_SEQ2_CONTROL: control_reg[2] <= cfg_data[CTRL_W-1:0];
                REG_SEQ3_CONTROL: control_reg[3] <= cfg_data[CTRL_W-1:0];
                default:          pattern_reg    <= pattern_reg;
            endcase
        end
    end

    ale_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ale_match #(
        .MAX_SEQ_LEN (MAX_SEQ_LEN),
        .NUM_SEQ     (NUM_SEQ),
        .CW          (CW)
    ) u_match (
        .clk         (clk),
        .store       (wr_en),
        .store_byte  (wr_data),
        .fill        (fill),
        .seq_pattern (pattern_reg),
        .seq_control (control_reg),
        .result      (match)
    );

    ale_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tdata  (s_axis_tdata),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser),
        .m_tlast  (m_axis_tlast),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .match    (match),
        .fill     (fill)
    );

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= CW'(DEPTH))
        else $error("ring fill count above depth");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (fill == CW'(DEPTH))) |=> (fill == CW'(DEPTH)))
        else $error("byte stored into a full ring");

    a_store_count: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (fill != CW'(DEPTH)))
            |=> (fill == $past(fill) + 1'b1))
        else $error("fill count not advanced on a stored byte");

    a_overflow_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_OVERFLOW))
            |-> ((m_axis_tdata == 8'h00) && m_axis_tlast))
        else $error("malformed overflow transfer");
`endif

endmodule
